/* design/ltq_pkg.sv */
`timescale 1ns / 1ps

package ltq_pkg;
    localparam int PoolNodes  = 64;
    localparam int StackDepth = 64;
    localparam int ValueBits  = 32;
    localparam int IdxBits    = $clog2(PoolNodes);
    localparam int SpBits     = $clog2(StackDepth);
    localparam int CntBits    = 7;

    localparam logic signed [31:0] SubtractReset = -32'sd65470464;
    localparam logic signed [31:0] SwapReset     = -32'sd58195968;

    typedef enum logic [2:0] {
        OP_ENQ    = 3'd0,
        OP_DEQ    = 3'd1,
        OP_DEL    = 3'd2,
        OP_INS    = 3'd3,
        OP_MAX    = 3'd4,
        OP_POP    = 3'd5,
        OP_EXEC   = 3'd6,
        OP_NONE   = 3'd7
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_QEMPTY   = 3'd1,
        ST_SEMPTY   = 3'd2,
        ST_BADH     = 3'd3,
        ST_POOLFULL = 3'd4,
        ST_STKFULL  = 3'd5,
        ST_SKIP     = 3'd6
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,       // read node (head or handle) and free slot
        S_EDIT,     // issue link writes
        S_EDIT2,    // second neighbor write
        S_MAXRD,
        S_MAXCMP,
        S_EXRD,
        S_EXNODE,
        S_EXSTK,
        S_EXSTK2,
        S_POPRD,
        S_OUT
    } state_t;

    localparam logic [IdxBits:0] NilLink = (IdxBits+1)'(PoolNodes);
endpackage

/* design/linked_task_queue_stack_engine.sv */
`timescale 1ns / 1ps

// Task queue (doubly linked list in a 64-node pool) plus a 64-entry value
// stack, all held in synchronous RAMs with one read and one write port
// each. One op at a time. Max visits every queued node in turn; execute-all
// pops each queued node and pushes it, drops it, or runs a subtract or swap
// on the stack. Each step is bounded by one read then one write on the node
// and stack memories.
// Results sit in an output register; the next op is taken once it drains.
module linked_task_queue_stack_engine
    import ltq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // opcode[2:0], task_value[34:3], node_handle[40:35]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // result_value[31:0], result_handle[37:32],
                                   // status[40:38], queue_length[47:41], stack_length[54:48]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int LW = IdxBits + 1;

    // memories
    logic [ValueBits-1:0] val_mem [PoolNodes];
    logic [LW-1:0]        prv_mem [PoolNodes];
    logic [LW-1:0]        nxt_mem [PoolNodes];
    logic [IdxBits-1:0]   free_mem [PoolNodes];
    logic [ValueBits-1:0] stk_mem [StackDepth];

    logic [PoolNodes-1:0] inuse_reg, inuse_next;
    logic [CntBits-1:0]   fcnt_reg, fcnt_next, qcnt_reg, qcnt_next, scnt_reg, scnt_next;
    logic [LW-1:0]        head_reg, head_next, tail_reg, tail_next;
    logic [31:0]          subc_reg, swpc_reg;
    state_t               st_reg, st_next;
    logic [2:0]           op_reg, op_next;
    logic [ValueBits-1:0] tv_reg, tv_next;
    logic [IdxBits-1:0]   h_reg, h_next, n_reg, n_next;
    logic [LW-1:0]        cur_reg, cur_next, nb_p_reg, nb_p_next, nb_n_reg, nb_n_next;
    logic [ValueBits-1:0] acc_reg, acc_next, x_reg, x_next, t_reg, t_next;
    status_t              sts_reg, sts_next;
    logic [5:0]           rh_reg, rh_next;
    logic [55:0]          out_reg, out_next;

    // read ports (registered data)
    logic [IdxBits-1:0]   nra, fra;
    logic [SpBits-1:0]    sra;
    logic [ValueBits-1:0] vrd, srd;
    logic [LW-1:0]        prd, nrd;
    logic [IdxBits-1:0]   frd;
    // write ports
    logic                 vwe, pwe, nwe, fwe, swe;
    logic [IdxBits-1:0]   vwa, pwa, nwa, fwa;
    logic [SpBits-1:0]    swa;
    logic [ValueBits-1:0] vwd, swd;
    logic [LW-1:0]        pwd, nwd;
    logic [IdxBits-1:0]   fwd;
    // second link writes (neighbor) share ports on later cycles

    always_ff @(posedge aclk) begin
        vrd <= val_mem[nra];
        prd <= prv_mem[nra];
        nrd <= nxt_mem[nra];
        frd <= free_mem[fra];
        srd <= stk_mem[sra];
        if (vwe) val_mem[vwa] <= vwd;
        if (pwe) prv_mem[pwa] <= pwd;
        if (nwe) nxt_mem[nwa] <= nwd;
        if (fwe) free_mem[fwa] <= fwd;
        if (swe) stk_mem[swa] <= swd;
    end

    // free list reset: a per-slot written flag; slots >= count never read before write,
    // entries below the reset count read as PoolNodes-1-i when not yet freed.
    logic [PoolNodes-1:0] fwr_reg, fwr_next;
    logic [IdxBits-1:0]   fra_q;
    logic [IdxBits-1:0]   free_top;
    always_ff @(posedge aclk) fra_q <= fra;
    assign free_top = fwr_reg[fra_q] ? frd : IdxBits'(PoolNodes - 1) - fra_q;

    assign pready   = 1'b1;
    assign s_tready = (st_reg == S_IDLE);
    assign m_tvalid = (st_reg == S_OUT);
    assign m_tdata  = out_reg;
    assign prdata   = (paddr[2] == 1'b0) ? subc_reg : swpc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            subc_reg <= SubtractReset;
            swpc_reg <= SwapReset;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == 1'b0) subc_reg <= pwdata;
            else swpc_reg <= pwdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= S_IDLE;
            inuse_reg <= '0;
            fwr_reg   <= '0;
            fcnt_reg  <= CntBits'(PoolNodes);
            qcnt_reg  <= '0;
            scnt_reg  <= '0;
            head_reg  <= NilLink;
            tail_reg  <= NilLink;
        end else begin
            st_reg    <= st_next;
            inuse_reg <= inuse_next;
            fwr_reg   <= fwr_next;
            fcnt_reg  <= fcnt_next;
            qcnt_reg  <= qcnt_next;
            scnt_reg  <= scnt_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg <= op_next; tv_reg <= tv_next; h_reg <= h_next; n_reg <= n_next;
        cur_reg <= cur_next; nb_p_reg <= nb_p_next; nb_n_reg <= nb_n_next;
        acc_reg <= acc_next; x_reg <= x_next; t_reg <= t_next;
        sts_reg <= sts_next; rh_reg <= rh_next;
        out_reg <= out_next;
    end

    // second minus top, saturated; srd holds second and t_reg top in S_EXSTK2
    logic signed [ValueBits:0] diff;
    logic [ValueBits-1:0]      satd;
    always_comb begin
        diff = {srd[ValueBits-1], srd} - {t_reg[ValueBits-1], t_reg};
        if (diff[ValueBits] != diff[ValueBits-1])
            satd = diff[ValueBits] ? {1'b1, {(ValueBits-1){1'b0}}}
                                   : {1'b0, {(ValueBits-1){1'b1}}};
        else
            satd = diff[ValueBits-1:0];
    end

    always_comb begin
        st_next = st_reg; inuse_next = inuse_reg; fwr_next = fwr_reg;
        fcnt_next = fcnt_reg; qcnt_next = qcnt_reg; scnt_next = scnt_reg;
        head_next = head_reg; tail_next = tail_reg;
        op_next = op_reg; tv_next = tv_reg; h_next = h_reg; n_next = n_reg;
        cur_next = cur_reg; nb_p_next = nb_p_reg; nb_n_next = nb_n_reg;
        acc_next = acc_reg; x_next = x_reg; t_next = t_reg;
        sts_next = sts_reg; rh_next = rh_reg; out_next = out_reg;
        nra = cur_reg[IdxBits-1:0];
        fra = IdxBits'(fcnt_reg - CntBits'(1));
        sra = SpBits'(scnt_reg - CntBits'(1));
        vwe = 1'b0; pwe = 1'b0; nwe = 1'b0; fwe = 1'b0; swe = 1'b0;
        vwa = n_reg; pwa = n_reg; nwa = n_reg; fwa = IdxBits'(fcnt_reg);
        vwd = tv_reg; pwd = NilLink; nwd = NilLink; fwd = cur_reg[IdxBits-1:0];
        swa = SpBits'(scnt_reg); swd = x_reg;

        case (st_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next  = s_tdata[2:0];
                    tv_next  = ValueBits'($signed(s_tdata[34:3]));
                    h_next   = s_tdata[40:35];
                    sts_next = ST_OK; rh_next = '0; acc_next = '0;
                    cur_next = (s_tdata[2:0] == OP_DEL || s_tdata[2:0] == OP_INS)
                             ? {1'b0, s_tdata[40:35]} : head_reg;
                    case (s_tdata[2:0])
                        OP_ENQ, OP_DEQ, OP_DEL, OP_INS: st_next = S_RD;
                        OP_MAX: st_next = (head_reg == NilLink) ? S_OUT : S_MAXRD;
                        OP_POP: st_next = S_POPRD;
                        OP_EXEC: st_next = (head_reg == NilLink) ? S_OUT : S_EXRD;
                        default: st_next = S_OUT;
                    endcase
                    if (s_tdata[2:0] == OP_NONE) sts_next = ST_SKIP;
                    if ((s_tdata[2:0] == OP_DEQ || s_tdata[2:0] == OP_MAX)
                        && head_reg == NilLink) begin
                        sts_next = ST_QEMPTY; st_next = S_OUT;
                    end
                    if (s_tdata[2:0] == OP_POP && scnt_reg == '0) begin
                        sts_next = ST_SEMPTY; st_next = S_OUT;
                    end
                end
            end
            S_RD: begin
                // memory reads addr cur_reg and free top this cycle
                st_next = S_EDIT;
                if ((op_reg == OP_DEL || op_reg == OP_INS) && !inuse_reg[h_reg]) begin
                    sts_next = ST_BADH; st_next = S_OUT;
                end else if ((op_reg == OP_ENQ || op_reg == OP_INS) && fcnt_reg == '0) begin
                    sts_next = ST_POOLFULL; st_next = S_OUT;
                end
            end
            S_EDIT: begin
                if (op_reg == OP_ENQ || op_reg == OP_INS) begin
                    n_next = free_top;
                    rh_next = 6'(free_top);
                    inuse_next[free_top] = 1'b1;
                    fcnt_next = fcnt_reg - CntBits'(1);
                    qcnt_next = qcnt_reg + CntBits'(1);
                    vwe = 1'b1; vwa = free_top;
                    pwe = 1'b1; pwa = free_top;
                    nwe = 1'b1; nwa = free_top;
                    if (op_reg == OP_ENQ) begin
                        pwd = tail_reg; nwd = NilLink;
                        nb_n_next = tail_reg;   // neighbor needing next=n
                        nb_p_next = NilLink;
                        if (tail_reg == NilLink) head_next = {1'b0, free_top};
                        tail_next = {1'b0, free_top};
                    end else begin
                        pwd = prd; nwd = cur_reg;
                        nb_n_next = prd;        // th.next = n
                        nb_p_next = cur_reg;    // p.prev = n
                        if (prd == NilLink) head_next = {1'b0, free_top};
                    end
                    st_next = S_EDIT2;
                end else begin
                    // unlink cur_reg
                    if (op_reg == OP_DEQ) acc_next = vrd;
                    inuse_next[cur_reg[IdxBits-1:0]] = 1'b0;
                    fwe = 1'b1; fwd = cur_reg[IdxBits-1:0];
                    fwr_next[fcnt_reg[IdxBits-1:0]] = 1'b1;
                    fcnt_next = fcnt_reg + CntBits'(1);
                    qcnt_next = qcnt_reg - CntBits'(1);
                    if (prd == NilLink) head_next = nrd;
                    else begin nwe = 1'b1; nwa = prd[IdxBits-1:0]; nwd = nrd; end
                    if (nrd == NilLink) tail_next = prd;
                    else begin pwe = 1'b1; pwa = nrd[IdxBits-1:0]; pwd = prd; end
                    st_next = S_OUT;
                end
            end
            S_EDIT2: begin
                if (nb_n_reg != NilLink) begin
                    nwe = 1'b1; nwa = nb_n_reg[IdxBits-1:0]; nwd = {1'b0, n_reg};
                end
                if (nb_p_reg != NilLink) begin
                    pwe = 1'b1; pwa = nb_p_reg[IdxBits-1:0]; pwd = {1'b0, n_reg};
                end
                st_next = S_OUT;
            end
            S_MAXRD: st_next = S_MAXCMP;
            S_MAXCMP: begin
                if (cur_reg == head_reg || $signed(vrd) > $signed(acc_reg)) acc_next = vrd;
                cur_next = nrd;
                st_next = (nrd == NilLink) ? S_OUT : S_MAXRD;
            end
            S_EXRD: st_next = S_EXNODE;
            S_EXNODE: begin
                // pop head node
                x_next = vrd;
                inuse_next[cur_reg[IdxBits-1:0]] = 1'b0;
                fwe = 1'b1; fwd = cur_reg[IdxBits-1:0];
                fwr_next[fcnt_reg[IdxBits-1:0]] = 1'b1;
                fcnt_next = fcnt_reg + CntBits'(1);
                qcnt_next = qcnt_reg - CntBits'(1);
                head_next = nrd;
                if (nrd == NilLink) tail_next = NilLink;
                else begin pwe = 1'b1; pwa = nrd[IdxBits-1:0]; pwd = NilLink; end
                cur_next = nrd;
                sra = SpBits'(scnt_reg - CntBits'(1));
                if (vrd == subc_reg || vrd == swpc_reg) begin
                    if (scnt_reg < CntBits'(2)) begin
                        if (sts_reg == ST_OK) sts_next = ST_SKIP;
                        st_next = (nrd == NilLink) ? S_OUT : S_EXRD;
                    end else st_next = S_EXSTK;
                end else begin
                    if (scnt_reg >= CntBits'(StackDepth)) begin
                        if (sts_reg == ST_OK) sts_next = ST_STKFULL;
                    end else begin
                        swe = 1'b1; swa = SpBits'(scnt_reg); swd = vrd;
                        scnt_next = scnt_reg + CntBits'(1);
                    end
                    st_next = (nrd == NilLink) ? S_OUT : S_EXRD;
                end
            end
            S_EXSTK: begin
                // srd = top; read second
                t_next = srd;
                sra = SpBits'(scnt_reg - CntBits'(2));
                st_next = S_EXSTK2;
            end
            S_EXSTK2: begin
                // srd = second
                if (x_reg == subc_reg) begin
                    swe = 1'b1; swa = SpBits'(scnt_reg - CntBits'(2));
                    swd = satd;
                    scnt_next = scnt_reg - CntBits'(1);
                    st_next = (cur_reg == NilLink) ? S_OUT : S_EXRD;
                end else begin
                    swe = 1'b1; swa = SpBits'(scnt_reg - CntBits'(2)); swd = t_reg;
                    x_next = srd;
                    st_next = S_POPRD; // write second value to top next
                    op_next = OP_NONE;
                end
            end
            S_POPRD: begin
                if (op_reg == OP_POP) begin
                    st_next = S_OUT; // data arrives registered, captured in S_OUT path
                    scnt_next = scnt_reg - CntBits'(1);
                    op_next = OP_POP;
                end else begin
                    swe = 1'b1; swa = SpBits'(scnt_reg - CntBits'(1)); swd = x_reg;
                    op_next = OP_EXEC;
                    st_next = (cur_reg == NilLink) ? S_OUT : S_EXRD;
                end
            end
            default: begin
                if (m_tready) st_next = S_IDLE;
            end
        endcase

        if (st_reg != S_OUT && st_next == S_OUT) begin
            out_next = {1'b0, scnt_next, qcnt_next, sts_next, rh_next, acc_next};
            if (st_reg == S_POPRD && op_reg == OP_POP)
                out_next[31:0] = srd;
        end
    end

`ifndef ASSERT_OFF
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(fcnt_reg) + 32'(qcnt_reg)) == PoolNodes)
        else $error("pool count mismatch");
    a_stk: assert property (@(posedge aclk) disable iff (!aresetn)
        scnt_reg <= CntBits'(StackDepth))
        else $error("stack count overflow");
    a_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (qcnt_reg == '0) == (head_reg == NilLink))
        else $error("head and count disagree");
`endif
endmodule

/* tb/ltq_result_checker.sv */
`timescale 1ns / 1ps

module ltq_result_checker
    import ltq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          fail_count,
    output int          pending_count
);
    typedef struct packed {
        logic [6:0]  stack_len;
        logic [6:0]  queue_len;
        status_t     status;
        logic [5:0]  handle;
        logic [31:0] value;
    } outcome_t;

    // Shadow copy of the block's queue and stack.
    logic signed [31:0] node_val [PoolNodes];
    logic [6:0]         toward_head [PoolNodes];
    logic [6:0]         toward_tail [PoolNodes];
    bit                 in_use [PoolNodes];
    logic [5:0]         free_list [PoolNodes];
    int                 free_n, head, tail, qlen, slen;
    logic signed [31:0] stk [StackDepth];
    logic signed [31:0] sub_code, swp_code;
    outcome_t           expected_q [$];

    localparam int Nil = PoolNodes;

    function automatic logic signed [31:0] sat_diff(logic signed [31:0] a,
                                                    logic signed [31:0] b);
        logic signed [32:0] d;
        d = 33'(a) - 33'(b);
        if (d > 33'sh0_7fff_ffff) return 32'sh7fff_ffff;
        if (d < -33'sh0_8000_0000) return 32'sh8000_0000;
        return d[31:0];
    endfunction

    function automatic int alloc_node(logic signed [31:0] v);
        int n;
        free_n--;
        n = free_list[free_n];
        in_use[n] = 1;
        node_val[n] = v;
        qlen++;
        return n;
    endfunction

    function automatic void unlink(int n);
        int th, tt;
        th = toward_head[n];
        tt = toward_tail[n];
        if (th == Nil) head = tt; else toward_tail[th] = 7'(tt);
        if (tt == Nil) tail = th; else toward_head[tt] = 7'(th);
        in_use[n] = 0;
        free_list[free_n] = 6'(n);
        free_n++;
        qlen--;
    endfunction

    function automatic outcome_t apply_op(opcode_t op, logic signed [31:0] v, int h);
        outcome_t r;
        int n, th;
        logic signed [31:0] x, t;
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_ENQ: begin
                if (free_n == 0) r.status = ST_POOLFULL;
                else begin
                    n = alloc_node(v);
                    toward_tail[n] = 7'(Nil);
                    toward_head[n] = 7'(tail);
                    if (tail == Nil) head = n; else toward_tail[tail] = 7'(n);
                    tail = n;
                    r.handle = 6'(n);
                end
            end
            OP_DEQ: begin
                if (head == Nil) r.status = ST_QEMPTY;
                else begin
                    r.value = node_val[head];
                    unlink(head);
                end
            end
            OP_DEL: begin
                if (!in_use[h]) r.status = ST_BADH; else unlink(h);
            end
            OP_INS: begin
                if (!in_use[h]) r.status = ST_BADH;
                else if (free_n == 0) r.status = ST_POOLFULL;
                else begin
                    n = alloc_node(v);
                    th = toward_head[h];
                    toward_tail[n] = 7'(h);
                    toward_head[n] = 7'(th);
                    if (th == Nil) head = n; else toward_tail[th] = 7'(n);
                    toward_head[h] = 7'(n);
                    r.handle = 6'(n);
                end
            end
            OP_MAX: begin
                if (head == Nil) r.status = ST_QEMPTY;
                else begin
                    x = node_val[head];
                    n = head;
                    while (n != Nil) begin
                        if (node_val[n] > x) x = node_val[n];
                        n = toward_tail[n];
                    end
                    r.value = x;
                end
            end
            OP_POP: begin
                if (slen == 0) r.status = ST_SEMPTY;
                else begin
                    slen--;
                    r.value = stk[slen];
                end
            end
            OP_EXEC: begin
                while (head != Nil) begin
                    x = node_val[head];
                    unlink(head);
                    if (x == sub_code || x == swp_code) begin
                        if (slen < 2) begin
                            if (r.status == ST_OK) r.status = ST_SKIP;
                        end else if (x == sub_code) begin
                            slen--;
                            stk[slen-1] = sat_diff(stk[slen-1], stk[slen]);
                        end else begin
                            t = stk[slen-1];
                            stk[slen-1] = stk[slen-2];
                            stk[slen-2] = t;
                        end
                    end else if (slen >= StackDepth) begin
                        if (r.status == ST_OK) r.status = ST_STKFULL;
                    end else begin
                        stk[slen] = x;
                        slen++;
                    end
                end
            end
            default: r.status = ST_SKIP;
        endcase
        r.queue_len = 7'(qlen);
        r.stack_len = 7'(slen);
        return r;
    endfunction

    always @(posedge aclk) begin
        outcome_t exp_r, got;
        if (!aresetn) begin
            for (int i = 0; i < PoolNodes; i++) begin
                in_use[i] = 0;
                free_list[i] = 6'(PoolNodes - 1 - i);
            end
            free_n = PoolNodes;
            head = Nil;
            tail = Nil;
            qlen = 0;
            slen = 0;
            sub_code = SubtractReset;
            swp_code = SwapReset;
            expected_q.delete();
            fail_count <= 0;
            pending_count <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == 1'b0) sub_code = pwdata;
                else swp_code = pwdata;
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(apply_op(opcode_t'(s_tdata[2:0]), s_tdata[34:3],
                                              int'(s_tdata[40:35])));
            if (m_tvalid && m_tready) begin
                got = outcome_t'(m_tdata[54:0]);
                if (expected_q.size() == 0) begin
                    $error("result beat with no expectation: %h", m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got !== exp_r) begin
                        fail_count <= fail_count + 1;
                        if (got.value !== exp_r.value)
                            $error("result_value exp %h got %h", exp_r.value, got.value);
                        if (got.handle !== exp_r.handle)
                            $error("result_handle exp %0d got %0d", exp_r.handle, got.handle);
                        if (got.status !== exp_r.status)
                            $error("status exp %0d got %0d", exp_r.status, got.status);
                        if (got.queue_len !== exp_r.queue_len)
                            $error("queue_length exp %0d got %0d",
                                   exp_r.queue_len, got.queue_len);
                        if (got.stack_len !== exp_r.stack_len)
                            $error("stack_length exp %0d got %0d",
                                   exp_r.stack_len, got.stack_len);
                    end
                end
            end
            pending_count <= expected_q.size();
        end
    end
endmodule

/* tb/linked_task_queue_stack_engine_test.sv */
`timescale 1ns / 1ps

module linked_task_queue_stack_engine_test;
    import ltq_pkg::*;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [55:0] m_tdata;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count, pending_count;
    int          send_idle_pct, recv_stall_pct;
    int          quiet_cycles;
    logic signed [31:0] sub_code, swp_code;
    // Handles handed out recently, so delete/insert mostly hit live nodes.
    logic [5:0]  recent_handles [$];

    localparam logic [2:0] RegSubtract = 3'd0;
    localparam logic [2:0] RegSwap     = 3'd4;
    localparam int         WatchdogLimit = 20000;

    always #5 aclk = ~aclk;

    linked_task_queue_stack_engine dut (.*);

    ltq_result_checker checker_i (.*);

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit) begin
            $display("** linked_task_queue_stack_engine: FAILED **");
            $finish;
        end
    end

    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        psel = 1; pwrite = 1; paddr = addr; pwdata = data; penable = 0;
        @(negedge aclk);
        penable = 1;
        @(negedge aclk);
        psel = 0; penable = 0; pwrite = 0;
    endtask

    task automatic send_op(opcode_t op, logic [31:0] v, logic [5:0] h);
        while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
        s_tdata = {7'd0, h, v, op};
        s_tvalid = 1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        s_tvalid = 0;
    endtask

    task automatic drain_results();
        while (pending_count != 0) @(negedge aclk);
    endtask

    task automatic set_codes(logic [31:0] sc, logic [31:0] wc);
        drain_results();
        reg_write(RegSubtract, sc);
        reg_write(RegSwap, wc);
        sub_code = sc;
        swp_code = wc;
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(9))
            0: return sub_code;
            1: return swp_code;
            2: return 32'h7fff_ffff;
            3: return 32'h8000_0000;
            4, 5: return $urandom_range(200) << 16;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [5:0] pick_handle();
        if (recent_handles.size() != 0 && $urandom_range(9) < 8)
            return recent_handles[$urandom_range(recent_handles.size() - 1)];
        return 6'($urandom);
    endfunction

    task automatic random_op();
        int k;
        opcode_t op;
        k = $urandom_range(99);
        if (k < 40) op = OP_ENQ;
        else if (k < 50) op = OP_DEQ;
        else if (k < 60) op = OP_DEL;
        else if (k < 72) op = OP_INS;
        else if (k < 80) op = OP_MAX;
        else if (k < 89) op = OP_POP;
        else if (k < 97) op = OP_EXEC;
        else op = OP_NONE;
        send_op(op, rand_value(), pick_handle());
        while (recent_handles.size() > 16) void'(recent_handles.pop_front());
    endtask

    // Collect handles returned by successful enqueue and insert beats.
    always @(posedge aclk)
        if (m_tvalid && m_tready && m_tdata[40:38] == ST_OK && m_tdata[37:32] != 0)
            recent_handles.push_back(m_tdata[37:32]);

    initial begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
        sub_code = SubtractReset;
        swp_code = SwapReset;
        repeat (3) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // directed: empty cases, edits, calculator, overflow saturation
        send_op(OP_DEQ, 0, 0);
        send_op(OP_MAX, 0, 0);
        send_op(OP_POP, 0, 0);
        send_op(OP_EXEC, 0, 0);
        send_op(OP_DEL, 0, 6'd63);
        send_op(OP_INS, 32'h1, 6'd5);
        send_op(OP_NONE, 32'hffff_ffff, 6'h3f);
        send_op(OP_ENQ, SubtractReset, 0);
        send_op(OP_ENQ, 32'h7fff_ffff, 0);
        send_op(OP_ENQ, 32'h8000_0000, 0);
        send_op(OP_INS, 32'h0001_0000, 6'd1);
        send_op(OP_ENQ, SwapReset, 0);
        send_op(OP_ENQ, 32'h8000_0000, 0);
        send_op(OP_MAX, 0, 0);
        send_op(OP_DEL, 0, 6'd1);
        send_op(OP_ENQ, 32'h7fff_ffff, 0);
        send_op(OP_ENQ, SubtractReset, 0);
        send_op(OP_EXEC, 0, 0);
        send_op(OP_POP, 0, 0);
        send_op(OP_POP, 0, 0);
        // fill pool past full, then overflow the stack
        for (int i = 0; i < 66; i++) send_op(OP_ENQ, i << 16, 0);
        send_op(OP_INS, 32'h5, 6'd10);
        send_op(OP_EXEC, 0, 0);
        for (int i = 0; i < 10; i++) send_op(OP_ENQ, i, 0);
        send_op(OP_EXEC, 0, 0);
        send_op(OP_DEQ, 0, 0);

        set_codes(32'h8000_0000, 32'h7fff_ffff);
        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            if (phase == 4) set_codes(32'h0000_0000, 32'hffff_ffff);
            if (phase == 6) set_codes($urandom, $urandom);
            if (phase == 7) set_codes(SubtractReset, SwapReset);
            for (int i = 0; i < 155; i++) random_op();
            while (pending_count != 0) @(negedge aclk);
        end

        drain_results();
        if (fail_count == 0)
            $display("** linked_task_queue_stack_engine: PASSED **");
        else
            $display("** linked_task_queue_stack_engine: FAILED **");
        $finish;
    end
endmodule
